// ===== sv/pidsd_pkg.sv =====
// Shared types and constants for the PID controller with settle detection.
// Used by pid_controller_with_settle_detect; depends on nothing else.
// Holds the register map, fixed thresholds and pipeline stage records.
package pidsd_pkg;

  // Fixed thresholds of the settle logic. A zero value disables the check.
  localparam logic [16:0] EXIT_BAND  = 17'd0;
  localparam logic [15:0] TIMEOUT_MS = 16'd0;

  localparam int unsigned TIMER_W = 16;
  localparam int unsigned ERR_W   = 16;
  localparam int unsigned DT_W    = 10;
  localparam int unsigned DRIVE_W = 32;
  localparam int unsigned SUM_W   = 50;

  // Configuration register map.
  typedef enum logic [2:0] {
    REG_PROP_GAIN    = 3'd0,
    REG_INTEG_GAIN   = 3'd1,
    REG_DERIV_GAIN   = 3'd2,
    REG_INTEG_WINDOW = 3'd3,
    REG_SETTLE_BAND  = 3'd4,
    REG_SETTLE_MS    = 3'd5,
    REG_WIDE_BAND    = 3'd6,
    REG_WIDE_MS      = 3'd7
  } cfg_reg_t;

  // Operands held after the state update, ahead of the multipliers.
  typedef struct packed {
    logic signed [15:0] err;
    logic signed [16:0] diff;
    logic signed [31:0] acc;
    logic               settled;
  } opnd_t;

  // Registered products, ahead of the final add and saturate.
  typedef struct packed {
    logic signed [32:0] p_prod;
    logic signed [48:0] i_prod;
    logic signed [33:0] d_prod;
    logic               settled;
  } prod_t;

endpackage

// ===== sv/pid_controller_with_settle_detect.sv =====
// PID controller with integral window, sign-change integral reset and settle detection.
// Each accepted input word moves through the stage 1, stage 2 and output registers to out_*.
// Throughput: one word per cycle unless out_tready stalls; state updates in the accept cycle.
// The three gain multiplies and the final add/shift/saturate sit in later pipeline stages.
// Reset (rst_n low, synchronous) zeroes the gains, thresholds, controller state and pipeline valid flags.
// Depends on pidsd_pkg for the register map, thresholds and stage records.
module pid_controller_with_settle_detect (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration write port.
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] err_sample, [25:16] elapsed_ms, [31:26] zero
  input  logic [0:0]  in_tuser,   // [0] restart
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [31:0] drive
  output logic [0:0]  out_tuser   // [0] settled
);

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [15:0] prop_gain_r, integ_gain_r, deriv_gain_r, integ_window_r;
  logic [15:0] settle_band_r, settle_ms_r, wide_band_r, wide_ms_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prop_gain_r    <= '0;
      integ_gain_r   <= '0;
      deriv_gain_r   <= '0;
      integ_window_r <= '0;
      settle_band_r  <= '0;
      settle_ms_r    <= '0;
      wide_band_r    <= '0;
      wide_ms_r      <= '0;
    end else if (cfg_wr_en) begin
      case (pidsd_pkg::cfg_reg_t'(cfg_index))
        pidsd_pkg::REG_PROP_GAIN:    prop_gain_r    <= cfg_wdata;
        pidsd_pkg::REG_INTEG_GAIN:   integ_gain_r   <= cfg_wdata;
        pidsd_pkg::REG_DERIV_GAIN:   deriv_gain_r   <= cfg_wdata;
        pidsd_pkg::REG_INTEG_WINDOW: integ_window_r <= cfg_wdata;
        pidsd_pkg::REG_SETTLE_BAND:  settle_band_r  <= cfg_wdata;
        pidsd_pkg::REG_SETTLE_MS:    settle_ms_r    <= cfg_wdata;
        pidsd_pkg::REG_WIDE_BAND:    wide_band_r    <= cfg_wdata;
        pidsd_pkg::REG_WIDE_MS:      wide_ms_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline flow control. Each stage loads when it is empty or when the stage
  // after it moves on, so bubbles are squeezed out and the input keeps accepting
  // while a finished result waits at the output, until stages 1 and 2 are full.
  // ---------------------------------------------------------------------------
  logic s1_valid_r, s2_valid_r, out_valid_r;
  logic rdy1, rdy2, rdy3, in_fire;

  assign rdy3      = !out_valid_r || out_tready;
  assign rdy2      = !s2_valid_r || rdy3;
  assign rdy1      = !s1_valid_r || rdy2;
  assign in_tready = rdy1;
  assign in_fire   = in_tvalid && rdy1;

  // ---------------------------------------------------------------------------
  // Input word unpacking.
  // ---------------------------------------------------------------------------
  logic signed [15:0] e_in;
  logic [9:0]         dt_in;
  logic               restart_in;

  assign e_in       = signed'(in_tdata[15:0]);
  assign dt_in      = in_tdata[25:16];
  assign restart_in = in_tuser[0];

  // ---------------------------------------------------------------------------
  // Controller state, updated in the cycle the word is accepted.
  // ---------------------------------------------------------------------------
  logic signed [31:0] integ_sum_r, integ_sum_nxt;
  logic signed [15:0] last_err_r, last_err_nxt;
  logic [15:0]        small_time_r, small_time_nxt;
  logic [15:0]        large_time_r, large_time_nxt;
  logic [15:0]        run_time_r, run_time_nxt;
  logic               exit_flag_r, exit_flag_nxt;

  logic [15:0]        mag;
  logic signed [32:0] acc_add;
  logic signed [31:0] acc_win;
  logic               sign_change;
  logic               e_zero, last_zero;
  logic [16:0]        small_add, large_add, run_add;
  logic               exit_hit, exit_seen;
  logic               timeout_done, band_done, settled_now;
  logic signed [16:0] diff_now;
  pidsd_pkg::opnd_t   s1_nxt;

  always_comb begin
    // Magnitude of the error; the most negative sample maps to 32768, which fits.
    mag = e_in[15] ? 16'(-e_in) : 16'(e_in);

    // Windowed integration with saturation at the signed 32-bit limits.
    acc_add = {integ_sum_r[31], integ_sum_r} + 33'(e_in);
    if (mag < integ_window_r) begin
      if (acc_add[32] != acc_add[31]) begin
        acc_win = acc_add[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end else begin
        acc_win = acc_add[31:0];
      end
    end else begin
      acc_win = integ_sum_r;
    end

    // Zero counts as a sign of its own, so a move to or from zero also clears.
    e_zero      = (e_in == '0);
    last_zero   = (last_err_r == '0);
    sign_change = (e_zero != last_zero) || (!e_zero && (e_in[15] != last_err_r[15]));

    diff_now = 17'(e_in) - 17'(last_err_r);

    // Timers add the elapsed time and stick at full scale.
    small_add = 17'(small_time_r) + 17'(dt_in);
    large_add = 17'(large_time_r) + 17'(dt_in);
    run_add   = 17'(run_time_r) + 17'(dt_in);

    small_time_nxt = (mag < settle_band_r) ? (small_add[16] ? 16'hFFFF : small_add[15:0]) : '0;
    large_time_nxt = (mag < wide_band_r) ? (large_add[16] ? 16'hFFFF : large_add[15:0]) : '0;
    run_time_nxt   = run_add[16] ? 16'hFFFF : run_add[15:0];

    exit_hit  = (pidsd_pkg::EXIT_BAND != '0) && ({1'b0, mag} < pidsd_pkg::EXIT_BAND);
    exit_seen = exit_flag_r || exit_hit;

    // Settle priority: run timeout, then either band timer, then the exit flag.
    // The exit flag is consumed only when it alone reports settled.
    timeout_done = (pidsd_pkg::TIMEOUT_MS != '0) && (run_time_nxt > pidsd_pkg::TIMEOUT_MS);
    band_done    = (small_time_nxt > settle_ms_r) || (large_time_nxt > wide_ms_r);
    settled_now  = timeout_done || band_done || exit_seen;
    exit_flag_nxt = exit_seen && (timeout_done || band_done);

    integ_sum_nxt = sign_change ? '0 : acc_win;
    last_err_nxt  = e_in;

    // A restart word clears the state and carries zero operands, so it
    // comes out as zero drive and not settled.
    if (restart_in) begin
      integ_sum_nxt  = '0;
      last_err_nxt   = '0;
      small_time_nxt = '0;
      large_time_nxt = '0;
      run_time_nxt   = '0;
      exit_flag_nxt  = 1'b0;
      s1_nxt         = '0;
    end else begin
      s1_nxt.err     = e_in;
      s1_nxt.diff    = diff_now;
      s1_nxt.acc     = integ_sum_nxt;
      s1_nxt.settled = settled_now;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integ_sum_r  <= '0;
      last_err_r   <= '0;
      small_time_r <= '0;
      large_time_r <= '0;
      run_time_r   <= '0;
      exit_flag_r  <= 1'b0;
    end else if (in_fire) begin
      integ_sum_r  <= integ_sum_nxt;
      last_err_r   <= last_err_nxt;
      small_time_r <= small_time_nxt;
      large_time_r <= large_time_nxt;
      run_time_r   <= run_time_nxt;
      exit_flag_r  <= exit_flag_nxt;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: operands. Stage 2: the three gain products. Stage 3: the sum,
  // floor shift by 8 (an arithmetic shift rounds toward minus infinity) and
  // saturation to 32 bits, held in the output register.
  // ---------------------------------------------------------------------------
  pidsd_pkg::opnd_t   s1_r;
  pidsd_pkg::prod_t   s2_r, s2_nxt;
  logic signed [pidsd_pkg::SUM_W-1:0] sum_full, sum_shr;
  logic [31:0]        drive_nxt;
  logic [31:0]        drive_r;
  logic               settled_r;

  always_comb begin
    s2_nxt.p_prod  = 33'(s1_r.err * $signed({1'b0, prop_gain_r}));
    s2_nxt.i_prod  = 49'(s1_r.acc * $signed({1'b0, integ_gain_r}));
    s2_nxt.d_prod  = 34'(s1_r.diff * $signed({1'b0, deriv_gain_r}));
    s2_nxt.settled = s1_r.settled;

    sum_full = pidsd_pkg::SUM_W'(s2_r.p_prod) + pidsd_pkg::SUM_W'(s2_r.i_prod)
             + pidsd_pkg::SUM_W'(s2_r.d_prod);
    sum_shr  = sum_full >>> 8;
    if (sum_shr > pidsd_pkg::SUM_W'(64'sh7FFF_FFFF)) begin
      drive_nxt = 32'h7FFF_FFFF;
    end else if (sum_shr < -pidsd_pkg::SUM_W'(64'sh8000_0000)) begin
      drive_nxt = 32'h8000_0000;
    end else begin
      drive_nxt = sum_shr[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      s2_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (rdy1) begin
        s1_valid_r <= in_fire;
      end
      if (rdy2) begin
        s2_valid_r <= s1_valid_r;
      end
      if (rdy3) begin
        out_valid_r <= s2_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && s1_valid_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && s2_valid_r) begin
      drive_r   <= drive_nxt;
      settled_r <= s2_r.settled;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = drive_r;
  assign out_tuser[0] = settled_r;

  // ---------------------------------------------------------------------------
  // Assertions.
  // ---------------------------------------------------------------------------
  // A restart word leaves the integrator, run timer and exit flag cleared.
  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && restart_in) |=> (integ_sum_r == '0 && run_time_r == '0 && !exit_flag_r))
    else $error("restart did not clear controller state");

  // The run timer never moves backward except on restart.
  a_run_time_mono: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && !restart_in) |=> (run_time_r >= $past(run_time_r)))
    else $error("run timer decreased without restart");

  // A change of error sign always empties the integrator.
  a_sign_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (in_fire && sign_change) |=> (integ_sum_r == '0))
    else $error("integrator kept its value across a sign change");

  // A stage that holds a word and cannot pass it on keeps it.
  a_s1_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !rdy2) |=> (s1_valid_r && $stable(s1_r)))
    else $error("stage 1 word lost while stalled");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for pid_controller_with_settle_detect.
// Needs pidsd_pkg and the controller RTL; drives stream and register ports,
// predicts every result word in a scoreboard class and compares field by field.
`timescale 1ns / 100ps

module tb;

  // One expected result word: the saturated drive and the settled flag.
  typedef struct {
    logic [31:0] drive;
    logic        settled;
  } pid_result_t;

  // The scoreboard keeps its own copy of the gains, thresholds and controller
  // state. note_input advances that copy for every accepted input word and
  // queues the result it implies; check_result pops and compares.
  class pid_scoreboard;
    localparam longint I32_MAX = 64'sd2147483647;
    localparam longint I32_MIN = -64'sd2147483648;

    longint kp, ki, kd;
    int window, small_band, small_ms, large_band, large_ms;
    longint integ_sum;
    int last_err, small_time, large_time, run_ms;
    bit exit_seen;
    pid_result_t due_results[$];
    int fails, words_in, words_out;

    function new();
      kp = 0; ki = 0; kd = 0;
      window = 0; small_band = 0; small_ms = 0; large_band = 0; large_ms = 0;
      fails = 0; words_in = 0; words_out = 0;
      clear_loop();
    endfunction

    function void clear_loop();
      integ_sum = 0; last_err = 0;
      small_time = 0; large_time = 0; run_ms = 0;
      exit_seen = 0;
    endfunction

    function void set_reg(pidsd_pkg::cfg_reg_t idx, logic [15:0] val);
      case (idx)
        pidsd_pkg::REG_PROP_GAIN:    kp = val;
        pidsd_pkg::REG_INTEG_GAIN:   ki = val;
        pidsd_pkg::REG_DERIV_GAIN:   kd = val;
        pidsd_pkg::REG_INTEG_WINDOW: window = val;
        pidsd_pkg::REG_SETTLE_BAND:  small_band = val;
        pidsd_pkg::REG_SETTLE_MS:    small_ms = val;
        pidsd_pkg::REG_WIDE_BAND:    large_band = val;
        pidsd_pkg::REG_WIDE_MS:      large_ms = val;
        default: ;
      endcase
    endfunction

    function longint clip32(longint v);
      if (v > I32_MAX) return I32_MAX;
      if (v < I32_MIN) return I32_MIN;
      return v;
    endfunction

    function int sgn(longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
    endfunction

    function int timer_add(int t, int d);
      int s;
      s = t + d;
      return (s > 65535) ? 65535 : s;
    endfunction

    function int pending();
      return due_results.size();
    endfunction

    task report(string msg);
      $display("[%0t] MISMATCH: %s", $time, msg);
      fails++;
    endtask

    function void note_input(logic signed [15:0] e, logic [9:0] dt, logic restart);
      longint ev, acc, total;
      int mag, dms;
      bit done;
      pid_result_t r;
      words_in++;
      ev = e;
      dms = dt;
      if (restart) begin
        clear_loop();
        r.drive = '0;
        r.settled = 1'b0;
        due_results.push_back(r);
        return;
      end
      mag = int'((ev < 0) ? -ev : ev);
      // The integral only grows inside the window and is dropped on any
      // change of error sign, where zero counts as a sign of its own.
      acc = integ_sum;
      if (mag < window) acc = clip32(acc + ev);
      if (sgn(ev) != sgn(last_err)) acc = 0;
      integ_sum = acc;
      total = kp * ev + ki * acc + kd * (ev - last_err);
      total = clip32(total >>> 8);
      last_err = int'(ev);
      small_time = (mag < small_band) ? timer_add(small_time, dms) : 0;
      large_time = (mag < large_band) ? timer_add(large_time, dms) : 0;
      if (pidsd_pkg::EXIT_BAND != 0 && mag < pidsd_pkg::EXIT_BAND) exit_seen = 1;
      run_ms = timer_add(run_ms, dms);
      if (pidsd_pkg::TIMEOUT_MS != 0 && run_ms > pidsd_pkg::TIMEOUT_MS) begin
        done = 1;
      end else if (small_time > small_ms || large_time > large_ms) begin
        done = 1;
      end else if (exit_seen) begin
        exit_seen = 0;
        done = 1;
      end else begin
        done = 0;
      end
      r.drive = total[31:0];
      r.settled = done;
      due_results.push_back(r);
    endfunction

    task check_result(logic [31:0] drive, logic settled);
      pid_result_t r;
      words_out++;
      if (due_results.size() == 0) begin
        report($sformatf("result word drive=%0d settled=%0b with nothing expected",
                         $signed(drive), settled));
        return;
      end
      r = due_results.pop_front();
      if (drive !== r.drive)
        report($sformatf("drive %0d, expected %0d", $signed(drive), $signed(r.drive)));
      if (settled !== r.settled)
        report($sformatf("settled %0b, expected %0b", settled, r.settled));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [2:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [31:0] in_tdata;   // [15:0] err_sample, [25:16] elapsed_ms, [31:26] zero
  logic [0:0]  in_tuser;   // [0] restart
  logic        out_tvalid;
  logic        out_tready;
  logic [31:0] out_tdata;  // [31:0] drive
  logic [0:0]  out_tuser;  // [0] settled

  pid_scoreboard board;
  // While calm is set neither side inserts idle cycles, so the block runs
  // at full rate with no backpressure.
  bit calm;
  int n_settings;
  int loop_err;

  pid_controller_with_settle_detect uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always #1 clk = ~clk;

  // Result side: every accepted result word is checked against the oldest
  // prediction. Values are read at the edge, before any update lands.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) board.check_result(out_tdata, out_tuser[0]);
  end

  // Result side backpressure: for each result word draw a random stall with
  // tready low, then hold tready high until a word is taken.
  // A zero stall leaves tready high, so it is never dropped and raised again
  // within the same time step.
  initial begin : ready_gen
    int stall;
    @(posedge rst_n);
    forever begin
      stall = calm ? 0 : $urandom_range(0, 11);
      if (stall > 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // Hard stop in case the block hangs; far beyond the slowest legal run
  // with the longest gaps and stalls on every word.
  initial begin
    #1000000;
    $display("pid_controller_with_settle_detect verification failed");
    $finish;
  end

  // Send one input word. The idle gap comes first; with a zero gap tvalid
  // simply stays high from the previous word. The word is noted in the
  // scoreboard at the edge where the handshake completes.
  task automatic send_word(logic signed [15:0] e, logic [9:0] dt, logic rs);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, dt, e};
    in_tuser  <= rs;
    do @(posedge clk); while (!in_tready);
    board.note_input(e, dt, rs);
  endtask

  // Stop sending and wait for every predicted result word to come back, so
  // that register writes only happen while the block is idle.
  task automatic drain();
    in_tvalid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(pidsd_pkg::cfg_reg_t idx, logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    board.set_reg(idx, val);
    @(posedge clk);
  endtask

  // Write all eight registers back to back; enable is lowered once at the end.
  task automatic apply_settings(logic [15:0] kp, logic [15:0] ki, logic [15:0] kd,
                                logic [15:0] win, logic [15:0] sband, logic [15:0] sms,
                                logic [15:0] wband, logic [15:0] wms);
    drain();
    write_reg(pidsd_pkg::REG_PROP_GAIN, kp);
    write_reg(pidsd_pkg::REG_INTEG_GAIN, ki);
    write_reg(pidsd_pkg::REG_DERIV_GAIN, kd);
    write_reg(pidsd_pkg::REG_INTEG_WINDOW, win);
    write_reg(pidsd_pkg::REG_SETTLE_BAND, sband);
    write_reg(pidsd_pkg::REG_SETTLE_MS, sms);
    write_reg(pidsd_pkg::REG_WIDE_BAND, wband);
    write_reg(pidsd_pkg::REG_WIDE_MS, wms);
    cfg_wr_en <= 1'b0;
    n_settings++;
  endtask

  // Random register setting. Gains and bands are mostly moderate so the loop
  // reaches its bands and the timers, with occasional full-range values.
  task automatic random_settings();
    logic [15:0] kp, ki, kd, win, sband, sms, wband, wms;
    kp    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 1024));
    ki    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 512));
    kd    = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(0, 65535))
                                        : 16'($urandom_range(0, 1024));
    win   = ($urandom_range(0, 3) == 0) ? 16'($urandom_range(0, 32768))
                                        : 16'($urandom_range(0, 3000));
    sband = ($urandom_range(0, 5) == 0) ? 16'd32768 : 16'($urandom_range(0, 200));
    sms   = ($urandom_range(0, 5) == 0) ? 16'd65535 : 16'($urandom_range(0, 300));
    wband = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 4000));
    wms   = ($urandom_range(0, 5) == 0) ? 16'd0 : 16'($urandom_range(0, 1500));
    apply_settings(kp, ki, kd, win, sband, sms, wband, wms);
  endtask

  task automatic new_target();
    loop_err = int'($urandom_range(0, 32767));
    if ($urandom_range(0, 1)) loop_err = -loop_err;
    if ($urandom_range(0, 19) == 0) loop_err = -32768;
  endtask

  // Random traffic. Most words follow a settling loop: the error decays from
  // a random step, overshoots now and then, and jitters around zero until a
  // new step arrives. The rest are restarts and unconstrained noise words.
  task automatic run_traffic(int count);
    int pick;
    logic [9:0] dt;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) calm = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      dt = ($urandom_range(0, 19) == 0) ? 10'($urandom_range(0, 1023))
                                        : 10'($urandom_range(1, 40));
      if (pick < 3) begin
        send_word(16'($urandom), 10'($urandom), 1'b1);
        new_target();
      end else if (pick < 13) begin
        send_word(16'($urandom), 10'($urandom), ($urandom_range(0, 7) == 0));
      end else begin
        send_word(16'(loop_err), dt, 1'b0);
        loop_err = loop_err * int'($urandom_range(60, 95)) / 100;
        if ($urandom_range(0, 9) == 0) loop_err = -loop_err;
        if (loop_err < 16 && loop_err > -16) begin
          loop_err = loop_err + int'($urandom_range(0, 6)) - 3;
          if ($urandom_range(0, 24) == 0) new_target();
        end
      end
    end
    calm = 0;
  endtask

  // Full-rate run of same-sign words at the largest in-window magnitude with
  // the longest elapsed time, long enough to pin the run and band timers at
  // their 16-bit ceiling while the integrator climbs steeply.
  task automatic integ_burst(logic signed [15:0] e);
    calm = 1;
    for (int i = 0; i < 70; i++) send_word(e, 10'd1023, 1'b0);
    calm = 0;
  endtask

  initial begin : main
    int guard;
    clk = 1'b0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    in_tuser = '0;
    out_tready = 1'b0;
    calm = 0;
    n_settings = 0;
    board = new();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset values: all gains and bands zero, so drive stays zero and
    // nothing settles.
    send_word(16'sd0, 10'd0, 1'b0);
    send_word(16'sd1000, 10'd5, 1'b0);
    send_word(-16'sd1000, 10'd1023, 1'b0);

    // Unity gains with small bands: window and band edges, field extremes,
    // sign changes through zero and a restart in the middle of a run.
    apply_settings(16'd256, 16'd256, 16'd256, 16'd100, 16'd50, 16'd10, 16'd1000, 16'd100);
    send_word(16'sd0, 10'd0, 1'b0);
    send_word(16'sd32767, 10'd1023, 1'b0);
    send_word(-16'sd32768, 10'd1023, 1'b0);
    send_word(-16'sd32768, 10'd0, 1'b0);
    send_word(16'sd99, 10'd3, 1'b0);
    send_word(16'sd99, 10'd3, 1'b0);
    send_word(16'sd100, 10'd3, 1'b0);
    send_word(16'sd49, 10'd10, 1'b0);
    send_word(16'sd49, 10'd1, 1'b0);
    send_word(16'sd0, 10'd5, 1'b0);
    send_word(-16'sd1, 10'd5, 1'b0);
    send_word(16'sd1, 10'd5, 1'b0);
    send_word(16'sd500, 10'd1023, 1'b1);
    send_word(16'sd999, 10'd100, 1'b0);
    send_word(16'sd1000, 10'd1, 1'b0);

    // Largest gains: products at their widest, drive near its limits.
    apply_settings(16'd65535, 16'd65535, 16'd65535, 16'd32768,
                   16'd32768, 16'd0, 16'd32768, 16'd0);
    send_word(16'sd32767, 10'd1, 1'b0);
    send_word(16'sd32767, 10'd1, 1'b0);
    send_word(-16'sd32767, 10'd1, 1'b0);
    send_word(-16'sd32768, 10'd1023, 1'b0);

    // Timer saturation with a fast-growing integrator in both directions.
    apply_settings(16'd65535, 16'd65535, 16'd65535, 16'd32768,
                   16'd32768, 16'd65535, 16'd32768, 16'd65535);
    integ_burst(16'sd32767);
    send_word(16'sd0, 10'd0, 1'b1);
    integ_burst(-16'sd32767);

    // Random traffic over several settings, both extreme corners first.
    new_target();
    apply_settings(16'd65535, 16'd65535, 16'd65535, 16'd32768,
                   16'd32768, 16'd0, 16'd32768, 16'd0);
    run_traffic(200);
    apply_settings(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    run_traffic(200);
    for (int p = 0; p < 4; p++) begin
      random_settings();
      run_traffic(200);
    end

    // Let the pipeline empty, then keep watching for any stray word.
    in_tvalid <= 1'b0;
    guard = 0;
    while (board.pending() != 0 && guard < 10000) begin
      @(posedge clk);
      guard++;
    end
    repeat (8) @(posedge clk);
    if (board.pending() != 0)
      board.report($sformatf("%0d result words never arrived", board.pending()));

    $display("Checked %0d result words from %0d input words over %0d register settings.",
             board.words_out, board.words_in, n_settings);
    $display("Included timer saturation runs at full rate and settling-loop traffic.");
    if (board.fails == 0) begin
      $display("pid_controller_with_settle_detect verification clean");
    end else begin
      $display("pid_controller_with_settle_detect verification failed");
    end
    $finish;
  end

endmodule

// ===== pid_controller_with_settle_detect.f =====
sv/pidsd_pkg.sv
sv/pid_controller_with_settle_detect.sv
verif/tb.sv
